// ===== rtl/tlpf_pkg.sv =====
// tlpf_pkg: shared constants, codes and types of the three level priority fifo
// used by the channel interfaces, the controller, the datapath and the top level
// no dependencies
package tlpf_pkg;

  localparam int DEPTH       = 16;
  localparam int HANDLE_BITS = 32;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int PRI_W       = 2;
  localparam int STAT_W      = 2;

  localparam logic FUNC_SUBMIT = 1'b0;
  localparam logic FUNC_TAKE   = 1'b1;

  localparam logic [PRI_W-1:0] LVL_LOWEST = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic load_item;
    logic exec;
  } tlpf_cmd_t;

endpackage

// ===== rtl/tlpf_if.sv =====
// tlpf_job_if and tlpf_result_if: valid/ready channels for jobs and results
// depends on tlpf_pkg
interface tlpf_job_if import tlpf_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   func;
  logic [PRI_W-1:0]       priority_req;
  logic [HANDLE_BITS-1:0] doc_handle;

  modport source (output valid, output func, output priority_req, output doc_handle,
                  input ready);
  modport sink   (input valid, input func, input priority_req, input doc_handle,
                  output ready);
endinterface

interface tlpf_result_if import tlpf_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [STAT_W-1:0]      status;
  logic [PRI_W-1:0]       out_priority;
  logic [HANDLE_BITS-1:0] out_handle;
  logic [CNT_W-1:0]       occupancy;

  modport source (output valid, output status, output out_priority, output out_handle,
                  output occupancy, input ready);
  modport sink   (input valid, input status, input out_priority, input out_handle,
                  input occupancy, output ready);
endinterface

// ===== rtl/tlpf_ctrl.sv =====
// tlpf_ctrl: controller for the job holding register and the result register
// depends on tlpf_pkg
module tlpf_ctrl import tlpf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output tlpf_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_BUSY = 1'b1;

  logic state;
  logic state_next;
  logic res_valid;
  logic res_valid_next;
  logic out_free;
  logic accept;

  always_comb begin
    out_free      = !res_valid || out_ready;
    cmd.exec      = (state == S_BUSY) && out_free;
    in_ready      = (state == S_IDLE) || cmd.exec;
    accept        = in_valid && in_ready;
    cmd.load_item = accept;
    case (state)
      S_IDLE:  state_next = accept ? S_BUSY : S_IDLE;
      S_BUSY:  state_next = (cmd.exec && !accept) ? S_IDLE : S_BUSY;
      default: state_next = S_IDLE;
    endcase
    if (cmd.exec) begin
      res_valid_next = 1'b1;
    end else if (out_ready) begin
      res_valid_next = 1'b0;
    end else begin
      res_valid_next = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
    end
  end

  assign out_valid = res_valid;

endmodule

// ===== rtl/tlpf_datapath.sv =====
// tlpf_datapath: job holding register, shift-insertion cell chain and result register
// depends on tlpf_pkg
module tlpf_datapath import tlpf_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  tlpf_cmd_t              cmd,
  input  logic                   func,
  input  logic [PRI_W-1:0]       priority_req,
  input  logic [HANDLE_BITS-1:0] doc_handle,
  output logic [STAT_W-1:0]      status,
  output logic [PRI_W-1:0]       out_priority,
  output logic [HANDLE_BITS-1:0] out_handle,
  output logic [CNT_W-1:0]       occupancy
);

  logic                   item_func;
  logic [PRI_W-1:0]       item_pri;
  logic [HANDLE_BITS-1:0] item_hnd;

  logic [PRI_W-1:0]       cell_pri [DEPTH];
  logic [HANDLE_BITS-1:0] cell_hnd [DEPTH];
  logic [CNT_W-1:0]       count;

  logic [DEPTH-1:0] keep;
  logic [DEPTH-1:0] ins_here;
  logic             full;
  logic             empty;

  // entries ahead of the new one form a prefix of the sorted chain
  always_comb begin
    full  = (count == CNT_W'(DEPTH));
    empty = (count == '0);
    for (int i = 0; i < DEPTH; i++) begin
      keep[i] = (CNT_W'(i) < count) && (cell_pri[i] <= item_pri);
    end
    ins_here[0] = !keep[0];
    for (int i = 1; i < DEPTH; i++) begin
      ins_here[i] = !keep[i] && keep[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_func <= func;
      item_pri  <= (priority_req > LVL_LOWEST) ? LVL_LOWEST : priority_req;
      item_hnd  <= doc_handle;
    end
    if (cmd.exec) begin
      out_priority <= '0;
      out_handle   <= '0;
      occupancy    <= count;
      status       <= STAT_OK;
      if (item_func == FUNC_SUBMIT) begin
        if (full) begin
          status <= STAT_FULL;
        end else begin
          occupancy <= count + 1'b1;
          for (int i = 0; i < DEPTH; i++) begin
            if (ins_here[i]) begin
              cell_pri[i] <= item_pri;
              cell_hnd[i] <= item_hnd;
            end else if (!keep[i] && i > 0) begin
              cell_pri[i] <= cell_pri[(i > 0) ? i - 1 : 0];
              cell_hnd[i] <= cell_hnd[(i > 0) ? i - 1 : 0];
            end
          end
        end
      end else begin
        if (empty) begin
          status <= STAT_EMPTY;
        end else begin
          out_priority <= cell_pri[0];
          out_handle   <= cell_hnd[0];
          occupancy    <= count - 1'b1;
          for (int i = 0; i < DEPTH - 1; i++) begin
            cell_pri[i] <= cell_pri[i+1];
            cell_hnd[i] <= cell_hnd[i+1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.exec) begin
      if (item_func == FUNC_SUBMIT) begin
        if (!full) begin
          count <= count + 1'b1;
        end
      end else if (!empty) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/three_level_priority_fifo_unit.sv =====
// three_level_priority_fifo_unit: top level of the three level priority fifo
// depends on tlpf_pkg, tlpf_if, tlpf_ctrl and tlpf_datapath
//
//   channel  dir  beat fields
//   job      in   func, priority_req, doc_handle
//   result   out  status, out_priority, out_handle, occupancy
//
// a job beat loads the holding register; in the next cycle, unless a stalled result
// holds the result register, the cell chain inserts or removes one entry and the
// result register loads, and the result beat is valid from the edge that loads it
// one job per cycle is sustained while results are taken; the cell chain update
// sets that figure
// a stalled result holds the result register and one further job waits in the
// holding register; reset empties the queue at once
module three_level_priority_fifo_unit import tlpf_pkg::*; (
  input logic      clk,
  input logic      rst,
  tlpf_job_if.sink      job,
  tlpf_result_if.source result
);

  tlpf_cmd_t cmd;

  tlpf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (job.valid),
    .in_ready  (job.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd)
  );

  tlpf_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .func         (job.func),
    .priority_req (job.priority_req),
    .doc_handle   (job.doc_handle),
    .status       (result.status),
    .out_priority (result.out_priority),
    .out_handle   (result.out_handle),
    .occupancy    (result.occupancy)
  );

  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.occupancy <= CNT_W'(DEPTH))
    else $error("occupancy beyond depth");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.status == STAT_FULL) |-> result.occupancy == CNT_W'(DEPTH))
    else $error("full status with room left");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.status == STAT_EMPTY) |->
      (result.occupancy == '0 && result.out_handle == '0))
    else $error("empty status with entries or handle");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !job.ready |-> (result.valid && !result.ready))
    else $error("job stalled without result backpressure");

endmodule
